FILE: rtl/kxc_pkg.sv
`default_nettype none

package kxc_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PASS   = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  // Minimal-standard generator constants, Schrage form.
  localparam logic [31:0] GEN_RECIP = 32'h834E_0B5F;
  localparam logic [16:0] GEN_Q     = 17'd127773;
  localparam logic [14:0] GEN_MUL   = 15'd16807;
  localparam logic [11:0] GEN_R     = 12'd2836;
  localparam logic [31:0] GEN_ADD   = 32'd123;
  localparam logic [31:0] GEN_FIX   = 32'h7FFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic load_init;  // take the key, reset chain and position
    logic set_pass;   // result is the word unchanged, pass-through status
    logic prep;       // apply first_word to chain and position
    logic read;       // issue the table read at the current position
    logic xform;      // compute the word and update chain and position
    logic g_mul;      // generator: reciprocal multiply
    logic g_quo;      // generator: quotient products
    logic g_rem;      // generator: remainder
    logic g_scale;    // generator: remainder times multiplier
    logic g_sum;      // generator: final sum, fix-up and table write
    logic out_load;   // move the finished result into the output register
  } kxc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic pass;
    logic word_zero;
    logic gen_last;
    logic out_full;
  } kxc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/kxc_if.sv
`default_nettype none

interface kxc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] word_in;
  logic        first_word;

  modport source (output valid, output op, output word_in, output first_word, input ready);
  modport sink (input valid, input op, input word_in, input first_word, output ready);
endinterface

interface kxc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_out;
  logic [1:0]  status;

  modport source (output valid, output word_out, output status, input ready);
  modport sink (input valid, input word_out, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/kxc_ctrl.sv
`default_nettype none

module kxc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  kxc_pkg::kxc_stat_t stat,
  output kxc_pkg::kxc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_G1     = 4'd2;
  localparam logic [3:0] S_G2     = 4'd3;
  localparam logic [3:0] S_G3     = 4'd4;
  localparam logic [3:0] S_G4     = 4'd5;
  localparam logic [3:0] S_G5     = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_XF     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_load) begin
          cmd.load_init = 1'b1;
          state_next    = stat.word_zero ? S_FIN : S_G1;
        end else if (stat.pass) begin
          cmd.set_pass = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.prep   = 1'b1;
          state_next = S_RD;
        end
      end
      S_G1: begin
        cmd.g_mul  = 1'b1;
        state_next = S_G2;
      end
      S_G2: begin
        cmd.g_quo  = 1'b1;
        state_next = S_G3;
      end
      S_G3: begin
        cmd.g_rem  = 1'b1;
        state_next = S_G4;
      end
      S_G4: begin
        cmd.g_scale = 1'b1;
        state_next  = S_G5;
      end
      S_G5: begin
        cmd.g_sum  = 1'b1;
        state_next = stat.gen_last ? S_FIN : S_G1;
      end
      S_RD: begin
        cmd.read   = 1'b1;
        state_next = S_XF;
      end
      S_XF: begin
        cmd.xform  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/kxc_datapath.sv
`default_nettype none

module kxc_datapath #(
  parameter int TABLE_WORDS = 130
) (
  input  logic               clk,
  input  logic               rst,
  input  kxc_pkg::kxc_cmd_t  cmd,
  output kxc_pkg::kxc_stat_t stat,
  input  logic [1:0]         op,
  input  logic [31:0]        word_in,
  input  logic               first_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        word_out,
  output logic [1:0]         status
);

  localparam int IDX_W = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int POS_W = $clog2(TABLE_WORDS + 1);

  // Captured request.
  logic [1:0]  op_r;
  logic [31:0] word_r;
  logic        first_r;

  // Architectural state.
  logic [31:0]      key_value;
  logic [31:0]      chain_value;
  logic [POS_W-1:0] pos;

  // Key table.
  logic [31:0] key_table [TABLE_WORDS];
  logic [31:0] rd_data;

  // Generator pipeline registers.
  logic [31:0]        gk;
  logic signed [15:0] t_r;
  logic [31:0]        qq_r;
  logic [31:0]        tr_r;
  logic signed [17:0] rem_r;
  logic [31:0]        rm_r;
  logic [15:0]        lo_r;
  logic               hsel;
  logic [IDX_W-1:0]   widx;

  // Staged result and output register.
  logic [31:0] res_word;
  logic [1:0]  res_status;

  logic signed [64:0] prod;
  logic signed [16:0] tq;
  logic signed [16:0] tf;
  logic signed [34:0] qq_full;
  logic signed [29:0] tr_full;
  logic signed [32:0] rm_full;
  logic [31:0]        gsum;
  logic [31:0]        gfix;
  logic               beyond;
  logic [31:0]        xres;

  always_comb begin
    prod    = $signed(gk) * $signed({1'b0, kxc_pkg::GEN_RECIP});
    tq      = t_r[15] ? (17'(t_r) + 17'sd1) : 17'(t_r);
    tf      = t_r[15] ? (17'(t_r) - 17'sd1) : 17'(t_r);
    qq_full = tq * $signed({1'b0, kxc_pkg::GEN_Q});
    tr_full = tf * $signed({1'b0, kxc_pkg::GEN_R});
    // The remainder carries the sign of the key.
    rm_full = rem_r * $signed({1'b0, kxc_pkg::GEN_MUL});
    gsum    = rm_r - tr_r + kxc_pkg::GEN_ADD;
    gfix    = ((gsum == 32'd0) || gsum[31]) ? (gsum + kxc_pkg::GEN_FIX) : gsum;
    beyond  = (pos >= POS_W'(TABLE_WORDS));
    xres    = word_r ^ rd_data ^ chain_value;
  end

  always_comb begin
    stat.is_load   = (op_r == kxc_pkg::OP_LOAD);
    stat.pass      = (op_r == kxc_pkg::OP_RSVD) || (key_value == 32'd0);
    stat.word_zero = (word_r == 32'd0);
    stat.gen_last  = hsel && (widx == IDX_W'(TABLE_WORDS - 1));
    stat.out_full  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op;
      word_r  <= word_in;
      first_r <= first_word;
    end
  end

  // Key, chain and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_value   <= '0;
      chain_value <= '0;
      pos         <= '0;
    end else if (cmd.load_init) begin
      key_value   <= word_r;
      chain_value <= word_r;
      pos         <= '0;
    end else if (cmd.prep) begin
      if (first_r) begin
        chain_value <= key_value;
        pos         <= '0;
      end
    end else if (cmd.xform && !beyond) begin
      chain_value <= (op_r == kxc_pkg::OP_ENC) ? xres : word_r;
      pos         <= pos + POS_W'(1);
    end
  end

  // Staged result.
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      res_word   <= word_r;
      res_status <= kxc_pkg::ST_OK;
    end else if (cmd.set_pass) begin
      res_word   <= word_r;
      res_status <= kxc_pkg::ST_PASS;
    end else if (cmd.xform) begin
      if (beyond) begin
        res_word   <= word_r;
        res_status <= kxc_pkg::ST_BEYOND;
      end else begin
        res_word   <= xres;
        res_status <= kxc_pkg::ST_OK;
      end
    end
  end

  // Generator steps.
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      gk <= word_r;
    end else if (cmd.g_sum) begin
      gk <= gfix;
    end
    if (cmd.g_mul) begin
      t_r <= prod[63:48];
    end
    if (cmd.g_quo) begin
      qq_r <= qq_full[31:0];
      tr_r <= 32'(tr_full);
    end
    if (cmd.g_rem) begin
      rem_r <= 18'(gk - qq_r);
    end
    if (cmd.g_scale) begin
      rm_r <= rm_full[31:0];
    end
    if (cmd.g_sum && !hsel) begin
      lo_r <= gfix[15:0];
    end
  end

  // Half select and word index of the table build.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsel <= 1'b0;
      widx <= '0;
    end else if (cmd.load_init) begin
      hsel <= 1'b0;
      widx <= '0;
    end else if (cmd.g_sum) begin
      hsel <= !hsel;
      if (hsel) begin
        widx <= widx + IDX_W'(1);
      end
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.g_sum && hsel) begin
      key_table[widx] <= {gfix[15:0], lo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read && !beyond) begin
      rd_data <= key_table[pos[IDX_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word_out <= res_word;
      status   <= res_status;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/keyed_xor_chain_cipher.sv
`default_nettype none

// Keyed XOR chain cipher. A load request (op 0) takes a 32-bit key and,
// when the key is nonzero, expands it into a table of TABLE_WORDS words by
// running two minimal-standard generator steps per word; encrypt (op 1) and
// decrypt (op 2) requests each transform one 32-bit packet word as
// word ^ table[position] ^ chain, where first_word restarts the chain at the
// key and the position at zero. A zero key passes words through unchanged
// with status 1, op 3 does the same, and words past the end of the table
// come back unchanged with status 2. Every request returns exactly one
// result. The block works on one request at a time: the input is ready only
// while the controller is idle, and a finished result sits in an output
// register so the next request can be taken while it waits. An encrypt or
// decrypt request runs through capture, decode, table memory read, transform
// and output load; a pass-through request through capture, decode and output
// load. A load with a nonzero key runs two generator steps for each table
// word, each step going through a reciprocal multiply, the Schrage quotient
// and remainder products and a final sum, and the table memory is written
// once for every two steps. A load of key zero leaves the table untouched.

module keyed_xor_chain_cipher #(
  parameter int TABLE_WORDS = 130
) (
  input logic      clk,
  input logic      rst,
  kxc_in_if.sink   item,
  kxc_out_if.source result
);

  kxc_pkg::kxc_cmd_t  cmd;
  kxc_pkg::kxc_stat_t stat;

  // The controller sequences each request; the datapath holds all state.
  kxc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kxc_datapath #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (item.op),
    .word_in    (item.word_in),
    .first_word (item.first_word),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .word_out   (result.word_out),
    .status     (result.status)
  );

endmodule

`default_nettype wire
